[rtl/hcbd_pkg.sv]
// Shared types and constants of the chunked body decoder.
// Beat structs, result kind codes and the framing characters.
// No dependencies.
package hcbd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
  } out_beat_t;

  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

endpackage

[rtl/http_chunked_body_decoder_unit.sv]
// Top level of the HTTP/1.1 chunked body decoder.
// Input register, parser and output register. Depends on hcbd_pkg and
// hcbd_parser.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_beat_i) carries one body
//   byte per beat; first_byte marks the first byte of a message and
//   restarts the parser before that byte is taken.
//   Output channel (out_valid_o / out_stall_i / out_beat_o) carries zero or
//   one result per input beat: a payload byte (kind DATA), message
//   complete (kind DONE) or a format error (kind ERROR, byte zero).
//   Size lines, blanks, extensions and the CR LF after each chunk produce
//   no beat. After DONE or ERROR, bytes are dropped until first_byte.
//   Path: an accepted input beat is registered in the input register, and
//   its result is registered in the result register when the parser
//   retires the byte.
//   Throughput: one byte per cycle unless in_stall_o is high; the phase
//   and size registers are updated in a single pass per byte.
//   Stall: an output beat held by out_stall_i blocks only a byte that has a
//   result; the input register then holds and in_stall_o rises. Bytes
//   without a result keep flowing.
//   Reset: clears the valid flags of both beat registers and puts the
//   parser at the start of a size line with size zero.
module http_chunked_body_decoder_unit #(
  parameter int SIZE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hcbd_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hcbd_pkg::out_beat_t  out_beat_o
);
  import hcbd_pkg::*;

  logic      s1_valid_q;
  in_beat_t  s1_q;
  logic      out_valid_q;
  out_beat_t out_q;

  logic      res_valid;
  out_beat_t res;
  logic      out_free;
  logic      advance;

  // Output register may be loaded when empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Retire the staged byte unless it has a result with nowhere to go.
  assign advance    = s1_valid_q && (!res_valid || out_free);
  assign in_stall_o = s1_valid_q && !advance;

  hcbd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (advance),
    .beat_i     (s1_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Input register: take a new beat whenever the stage is not held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_beat_i;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i && res_valid)
    else $error("input stalled without a blocked result");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |-> !(out_valid_q && out_stall_i))
    else $error("result retired into a held output register");

  a_status_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.kind != KIND_DATA |-> out_beat_o.out_byte == 8'h00)
    else $error("status beat carries a nonzero byte");
`endif

endmodule

[rtl/hcbd_parser.sv]
// Per-byte parser of the chunked body decoder: phase and size registers
// and the next-state logic. Depends on hcbd_pkg.
module hcbd_parser #(
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  hcbd_pkg::in_beat_t    beat_i,
  output logic                  res_valid_o,
  output hcbd_pkg::out_beat_t   res_o
);
  import hcbd_pkg::*;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_DIGITS = 4'd1,
    PH_TRAIL  = 4'd2,
    PH_EXT    = 4'd3,
    PH_LF     = 4'd4,
    PH_DATA   = 4'd5,
    PH_SKIP1  = 4'd6,
    PH_SKIP2  = 4'd7,
    PH_ZCR    = 4'd8,
    PH_ZLF    = 4'd9,
    PH_DONE   = 4'd10,
    PH_ERROR  = 4'd11
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] size_q, size_d;

  logic [7:0]           b;
  logic                 is_dig;
  logic [3:0]           dval;
  logic                 is_blank;
  phase_e               ph_a, ph_b;
  logic [SIZE_BITS-1:0] sz_a;
  logic                 skip;

  assign b        = beat_i.in_byte;
  assign is_blank = (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_LF);

  // Hex digit decode, either case.
  always_comb begin
    is_dig = 1'b0;
    dval   = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      is_dig = 1'b1;
      dval   = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      is_dig = 1'b1;
      dval   = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      is_dig = 1'b1;
      dval   = 4'(b - 8'h37);
    end
  end

  always_comb begin
    ph_a = phase_q;
    sz_a = size_q;
    if (beat_i.first_byte) begin
      ph_a = PH_LEAD;
      sz_a = '0;
    end
    phase_d     = ph_a;
    size_d      = sz_a;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: 8'h00, kind: KIND_DATA};
    skip        = 1'b0;
    ph_b        = ph_a;
    // A pending line end resolves here; a byte other than LF is then
    // handled in the phase that the line leads to.
    if (ph_a == PH_LF) begin
      ph_b    = (sz_a == '0) ? PH_ZCR : PH_DATA;
      phase_d = ph_b;
      skip    = (b == CHAR_LF);
    end
    if (!skip) begin
      unique case (ph_b) inside
        PH_LEAD, PH_DIGITS: begin
          if (is_dig) begin
            if (sz_a[SIZE_BITS-1 -: 4] != 4'd0) begin
              phase_d     = PH_ERROR;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_ERROR;
            end else begin
              size_d  = {sz_a[SIZE_BITS-5:0], dval};
              phase_d = PH_DIGITS;
            end
          end else if (is_blank) begin
            if (ph_b == PH_DIGITS) phase_d = PH_TRAIL;
          end else if (ph_b == PH_DIGITS && b == CHAR_SEMI) begin
            phase_d = PH_EXT;
          end else if (ph_b == PH_DIGITS && b == CHAR_CR) begin
            phase_d = PH_LF;
          end else begin
            phase_d     = PH_ERROR;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ERROR;
          end
        end
        PH_TRAIL: begin
          if (is_blank) begin
            phase_d = PH_TRAIL;
          end else if (b == CHAR_SEMI) begin
            phase_d = PH_EXT;
          end else if (b == CHAR_CR) begin
            phase_d = PH_LF;
          end else begin
            phase_d     = PH_ERROR;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ERROR;
          end
        end
        PH_EXT: begin
          if (b == CHAR_CR) phase_d = PH_LF;
        end
        PH_DATA: begin
          size_d = sz_a - SIZE_BITS'(1);
          if (size_d == '0) phase_d = PH_SKIP1;
          res_valid_o    = 1'b1;
          res_o.out_byte = b;
          res_o.kind     = KIND_DATA;
        end
        PH_SKIP1: begin
          phase_d = PH_SKIP2;
        end
        PH_SKIP2: begin
          phase_d = PH_LEAD;
          size_d  = '0;
        end
        PH_ZCR: begin
          res_o.kind = KIND_ERROR;
          if (b == CHAR_CR) begin
            phase_d = PH_ZLF;
          end else begin
            phase_d     = PH_ERROR;
            res_valid_o = 1'b1;
          end
        end
        PH_ZLF: begin
          res_valid_o = 1'b1;
          if (b == CHAR_LF) begin
            phase_d    = PH_DONE;
            res_o.kind = KIND_DONE;
          end else begin
            phase_d    = PH_ERROR;
            res_o.kind = KIND_ERROR;
          end
        end
        default: begin
          // Done, error and unused codes: drop the byte.
          phase_d = ph_b;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      size_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      size_q  <= size_d;
    end
  end

endmodule
